// ===== hw/rtl/mexp_pkg.sv =====
// shared types and constants for the modular exponentiation block
package mexp_pkg;

  localparam int unsigned BASE_WIDTH        = 63;
  localparam int unsigned EXP_IN_WIDTH      = 63;
  localparam int unsigned MOD_IN_WIDTH      = 31;
  localparam int unsigned EXP_WIDTH_DEFAULT = 63;
  localparam int unsigned MOD_WIDTH_DEFAULT = 31;

  localparam logic [MOD_IN_WIDTH-1:0] MODULUS_RESET = 31'd1000000007;

  // width of the shared unit's loop counter, wide enough to count a full base value
  localparam int unsigned MM_CNT_WIDTH = $clog2(BASE_WIDTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SQUARE,
    ST_MULT
  } mexp_state_e;

  typedef struct packed {
    logic start;
    logic full_len;
  } mexp_mm_req_t;

endpackage

// ===== hw/rtl/mexp_mulmod.sv =====
// bit-serial interleaved modular multiplier, one multiplier bit per cycle
module mexp_mulmod #(
  parameter int unsigned MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mexp_pkg::mexp_mm_req_t           req_i,
  input  logic [mexp_pkg::BASE_WIDTH-1:0]  y_i,
  input  logic [MOD_WIDTH-1:0]             x_i,
  input  logic [MOD_WIDTH-1:0]             m_i,
  output logic                             done_o,
  output logic [MOD_WIDTH-1:0]             result_o
);
  import mexp_pkg::*;

  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [MM_CNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [BASE_WIDTH-1:0]   y_q, y_d;
  logic [MOD_WIDTH-1:0]    r_q, r_d;

  logic [MOD_WIDTH:0] m_ext;
  logic [MOD_WIDTH:0] dbl;
  logic [MOD_WIDTH:0] dbl_red;
  logic [MOD_WIDTH:0] sum;
  logic [MOD_WIDTH:0] sum_red;

  // r = (2r + ybit*x) mod m, with r, x below m
  always_comb begin
    m_ext   = {1'b0, m_i};
    dbl     = {r_q, 1'b0};
    dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
    sum     = {1'b0, dbl_red[MOD_WIDTH-1:0]}
            + (y_q[BASE_WIDTH-1] ? {1'b0, x_i} : '0);
    sum_red = (sum >= m_ext) ? (sum - m_ext) : sum;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    y_d    = y_q;
    r_d    = r_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      r_d    = '0;
      y_d    = y_i;
      cnt_d  = req_i.full_len ? MM_CNT_WIDTH'(BASE_WIDTH) : MM_CNT_WIDTH'(MOD_WIDTH);
    end else if (busy_q) begin
      r_d   = sum_red[MOD_WIDTH-1:0];
      y_d   = y_q << 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == MM_CNT_WIDTH'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q <= y_d;
    r_q <= r_d;
  end

  assign done_o   = done_q;
  assign result_o = r_q;

  a_residue_below_modulus : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (m_i != '0)) |-> (r_q < m_i))
    else $error("modular product not reduced below modulus");

  a_no_start_while_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("multiplier launched while still running");

  a_done_single_pulse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("multiplier done held for more than one cycle");

endmodule

// ===== hw/rtl/modular_exponentiation.sv =====
// modular exponentiation top level: square and multiply over one shared modular multiplier
//
// start with base_value_i and exponent_i is taken when busy is low. the exponent is cut to
// its low EXP_WIDTH bits and the modulus to its low MOD_WIDTH bits. a zero exponent answers 1
// and a zero modulus answers 0 on the cycle after the item, without raising busy. otherwise
// the base is first reduced, then every exponent bit from the top down costs a squaring,
// plus a multiply by the base when the bit is set, each run in the bit-serial multiplier.
// the result shows on power_result_o for the single cycle in which done_o is high; the
// receiver cannot stall it, and busy is already low in that cycle so the next item may be
// started there. the modulus register is written through cfg_we_i and cfg_wdata_i; the
// user must write it only while the block is idle, the block itself does not enforce it,
// and it comes out of reset as 1000000007.
module modular_exponentiation #(
  parameter int unsigned EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEFAULT,
  parameter int unsigned MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mexp_pkg::MOD_IN_WIDTH-1:0]  cfg_wdata_i,
  input  logic                               start,
  output logic                               busy,
  input  logic [mexp_pkg::BASE_WIDTH-1:0]    base_value_i,
  input  logic [mexp_pkg::EXP_IN_WIDTH-1:0]  exponent_i,
  output logic                               done_o,
  output logic [mexp_pkg::MOD_IN_WIDTH-1:0]  power_result_o
);
  import mexp_pkg::*;

  localparam int unsigned BITS_WIDTH = $clog2(EXP_WIDTH + 1);
  localparam int unsigned PAD_WIDTH  = BASE_WIDTH - MOD_WIDTH;

  mexp_state_e state_q, state_d;

  logic [MOD_WIDTH-1:0]  modulus_q;
  logic [MOD_WIDTH-1:0]  acc_q, acc_d;
  logic [MOD_WIDTH-1:0]  base_q, base_d;
  logic [EXP_WIDTH-1:0]  exp_q, exp_d;
  logic [BITS_WIDTH-1:0] bits_q, bits_d;
  logic [MOD_WIDTH-1:0]  res_q, res_d;
  logic                  done_q, done_d;

  // multiplier hookup
  mexp_mm_req_t          mm_req;
  logic [BASE_WIDTH-1:0] mm_y;
  logic [MOD_WIDTH-1:0]  mm_x;
  logic                  mm_done;
  logic [MOD_WIDTH-1:0]  mm_res;

  logic                 accept;
  logic [EXP_WIDTH-1:0] exp_in;
  logic                 exp_zero;
  logic                 mod_zero;
  logic                 exp_msb;
  logic                 last_bit;

  assign accept   = start && !busy;
  assign exp_in   = exponent_i[EXP_WIDTH-1:0];
  assign exp_zero = (exp_in == '0);
  assign mod_zero = (modulus_q == '0);
  assign exp_msb  = exp_q[EXP_WIDTH-1];
  assign last_bit = (bits_q == BITS_WIDTH'(1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && !exp_zero && !mod_zero) state_d = ST_REDUCE;
      end
      ST_REDUCE: begin
        if (mm_done) state_d = ST_SQUARE;
      end
      ST_SQUARE: begin
        if (mm_done) begin
          priority if (exp_msb) state_d = ST_MULT;
          else if (last_bit)    state_d = ST_IDLE;
          else                  state_d = ST_SQUARE;
        end
      end
      ST_MULT: begin
        if (mm_done) state_d = last_bit ? ST_IDLE : ST_SQUARE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath control and launches of the shared multiplier
  always_comb begin
    acc_d           = acc_q;
    base_d          = base_q;
    exp_d           = exp_q;
    bits_d          = bits_q;
    res_d           = res_q;
    done_d          = 1'b0;
    mm_req.start    = 1'b0;
    mm_req.full_len = 1'b0;
    // by default the next operand is the product just finished, left aligned
    mm_y            = {mm_res, {PAD_WIDTH{1'b0}}};
    mm_x            = acc_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          // 1 mod m: zero for a modulus of one
          acc_d  = (modulus_q == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
          exp_d  = exp_in;
          bits_d = BITS_WIDTH'(EXP_WIDTH);
          if (exp_zero || mod_zero) begin
            done_d = 1'b1;
            res_d  = exp_zero ? MOD_WIDTH'(1) : '0;
          end else begin
            // base mod m, run as 1 * base through the multiplier
            mm_req.start    = 1'b1;
            mm_req.full_len = 1'b1;
            mm_y            = base_value_i;
          end
        end
      end
      ST_REDUCE: begin
        mm_x = MOD_WIDTH'(1);
        if (mm_done) begin
          base_d       = mm_res;
          mm_req.start = 1'b1;
          mm_y         = {acc_q, {PAD_WIDTH{1'b0}}};
        end
      end
      ST_SQUARE: begin
        mm_x = acc_q;
        if (mm_done) begin
          acc_d = mm_res;
          if (exp_msb) begin
            mm_req.start = 1'b1;
          end else begin
            exp_d  = exp_q << 1;
            bits_d = bits_q - 1'b1;
            if (last_bit) begin
              done_d = 1'b1;
              res_d  = mm_res;
            end else begin
              mm_req.start = 1'b1;
            end
          end
        end
      end
      ST_MULT: begin
        mm_x = base_q;
        if (mm_done) begin
          acc_d  = mm_res;
          exp_d  = exp_q << 1;
          bits_d = bits_q - 1'b1;
          if (last_bit) begin
            done_d = 1'b1;
            res_d  = mm_res;
          end else begin
            mm_req.start = 1'b1;
          end
        end
      end
      default: begin
        mm_x = acc_q;
      end
    endcase
  end

  mexp_mulmod #(
    .MOD_WIDTH (MOD_WIDTH)
  ) u_mulmod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mm_req),
    .y_i      (mm_y),
    .x_i      (mm_x),
    .m_i      (modulus_q),
    .done_o   (mm_done),
    .result_o (mm_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      done_q    <= 1'b0;
      modulus_q <= MODULUS_RESET[MOD_WIDTH-1:0];
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_we_i) modulus_q <= cfg_wdata_i[MOD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    base_q <= base_d;
    exp_q  <= exp_d;
    bits_q <= bits_d;
    res_q  <= res_d;
  end

  assign busy           = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign power_result_o = MOD_IN_WIDTH'(res_q);

  a_result_when_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while still working");

  a_item_answered_or_running : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy || done_o))
    else $error("accepted item neither answered nor in progress");

  a_mm_done_in_op_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_done |-> (state_q == ST_REDUCE || state_q == ST_SQUARE || state_q == ST_MULT))
    else $error("multiplier finished outside an operation");

endmodule

// ===== verif/tb_modular_exponentiation.sv =====
// self-checking testbench for the square-and-multiply modular exponentiation block
module tb_modular_exponentiation;
  timeunit 1ns;
  timeprecision 1ps;

  import mexp_pkg::*;

  // a quiet spell of several times the longest item is a hang
  localparam int unsigned STALL_LIMIT = 20000;
  // after the last result, wait out one full item time in case a stray strobe follows
  localparam int unsigned TAIL_CYCLES = 4200;
  localparam int unsigned PHASE_ITEMS = 17;
  localparam int unsigned NUM_PHASES  = 7;

  typedef logic [BASE_WIDTH-1:0]   base_t;
  typedef logic [EXP_IN_WIDTH-1:0] expo_t;
  typedef logic [MOD_IN_WIDTH-1:0] resid_t;

  typedef struct packed {
    base_t base;
    expo_t expo;
  } pow_item_t;

  localparam base_t  BASE_MAX = '1;
  localparam expo_t  EXP_MAX  = '1;
  localparam resid_t MOD_MAX  = '1;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #4 clk_i = ~clk_i;

  // block inputs start at known values
  logic   cfg_we_i     = 1'b0;
  resid_t cfg_wdata_i  = '0;
  logic   start        = 1'b0;
  base_t  base_value_i = '0;
  expo_t  exponent_i   = '0;

  logic   busy;
  logic   done_o;
  resid_t power_result_o;

  modular_exponentiation dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start         (start),
    .busy          (busy),
    .base_value_i  (base_value_i),
    .exponent_i    (exponent_i),
    .done_o        (done_o),
    .power_result_o(power_result_o)
  );

  // items waiting to be sent, and the powers we expect back, oldest first
  pow_item_t   pending_items[$];
  resid_t      expected_powers[$];
  // our own copy of the modulus register
  resid_t      modulus_shadow = MODULUS_RESET;
  // chance in a hundred that the sender holds back on a given cycle
  int unsigned idle_pct = 9;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;

  // base^expo mod m by scanning the exponent from the top bit down
  // zero exponent gives 1 even for modulus 1 or 0, zero modulus otherwise gives 0
  function automatic resid_t predict_power(base_t b, expo_t e, resid_t m);
    logic [63:0] wide_mod;
    logic [63:0] red_base;
    logic [63:0] acc;
    if (e == '0) return resid_t'(1);
    if (m == '0) return '0;
    wide_mod = 64'(m);
    red_base = 64'(b) % wide_mod;
    acc      = 64'd1 % wide_mod;
    // residues stay below 2^31 so every product fits in 64 bits
    for (int i = EXP_IN_WIDTH - 1; i >= 0; i--) begin
      acc = (acc * acc) % wide_mod;
      if (e[i]) acc = (acc * red_base) % wide_mod;
    end
    return acc[MOD_IN_WIDTH-1:0];
  endfunction

  function automatic base_t rand_wide();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[BASE_WIDTH-1:0];
  endfunction

  // random item, mostly full-width operands with a share of awkward shapes
  function automatic pow_item_t random_item(resid_t m);
    pow_item_t it;
    it.base = rand_wide();
    it.expo = rand_wide();
    case ($urandom_range(9))
      4: it.expo = expo_t'($urandom_range(16));
      5: begin
        // base right around the modulus, exercises the reduction
        it.base = base_t'(m) + base_t'($urandom_range(2)) - base_t'(1);
        it.expo = expo_t'($urandom_range(40));
      end
      6: it.expo = expo_t'(1) << $urandom_range(EXP_IN_WIDTH - 1);
      7: it.expo = '0;
      8: it.expo = EXP_MAX;
      9: it.base = base_t'($urandom_range(3));
      default: ;
    endcase
    return it;
  endfunction

  // driver: offers the next pending item once the current one has been taken
  always @(posedge clk_i) begin : drive_items
    pow_item_t next_item;
    logic      taken;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        expected_powers.push_back(predict_power(base_value_i, exponent_i, modulus_shadow));
      end
      if (!start || taken) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
          next_item    = pending_items.pop_front();
          start        <= 1'b1;
          base_value_i <= next_item.base;
          exponent_i   <= next_item.expo;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // the modulus copy follows every register write at the same edge as the block
  always @(posedge clk_i) begin
    if (rst_ni && cfg_we_i) modulus_shadow <= cfg_wdata_i;
  end

  // monitor: every strobe must match the oldest expectation
  always @(posedge clk_i) begin : check_powers
    resid_t want;
    if (rst_ni && done_o) begin
      if (expected_powers.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %0d", $time, power_result_o);
        fail_count++;
      end else begin
        want = expected_powers.pop_front();
        if (power_result_o !== want) begin
          $display("%0t: power_result mismatch, expected %0d, got %0d",
                   $time, want, power_result_o);
          fail_count++;
        end
      end
    end
  end

  // watchdog: too long without an item taken, a result or a register write
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || cfg_we_i || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, nothing moved for %0d cycles", $time, quiet_cycles);
      $display("tb_modular_exponentiation NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_item(base_t b, expo_t e);
    pending_items.push_back('{base: b, expo: e});
  endtask

  task automatic queue_item_struct(pow_item_t it);
    pending_items.push_back(it);
  endtask

  // wait until every pending item is sent and the block has answered everything
  task automatic drain();
    while (pending_items.size() != 0 || start || expected_powers.size() != 0)
      @(posedge clk_i);
  endtask

  // only called once drained, so the block is idle
  task automatic write_modulus(resid_t value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin : stimulus
    resid_t phase_mod;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed items on the modulus as it comes out of reset
    queue_item('0, '0);                               // zero exponent, zero base
    queue_item(BASE_MAX, '0);                         // zero exponent, widest base
    queue_item(BASE_MAX, expo_t'(1));                 // exponent one is just the reduction
    queue_item('0, EXP_MAX);                          // zero base, longest exponent
    queue_item(BASE_MAX, EXP_MAX);                    // every bit set on both sides
    queue_item(base_t'(MODULUS_RESET), expo_t'(5));   // base equal to the modulus
    queue_item(base_t'(MODULUS_RESET) - 1, expo_t'(2)); // minus one squared
    queue_item(base_t'(2), expo_t'(1) << (EXP_IN_WIDTH - 1)); // only the top bit
    queue_item(base_t'(12345), expo_t'(2));
    queue_item(base_t'(3), 63'h5555_5555_5555_5555);
    queue_item(rand_wide(), 63'h2AAA_AAAA_AAAA_AAAA);
    drain();

    // modulus one: only a zero exponent gives anything but zero
    write_modulus(resid_t'(1));
    queue_item(base_t'(7), '0);
    queue_item(BASE_MAX, expo_t'(9));
    queue_item('0, expo_t'(1));
    drain();

    // modulus zero is outside the useful range but the port allows it
    write_modulus('0);
    queue_item(base_t'(5), '0);
    queue_item(base_t'(5), expo_t'(3));
    queue_item(BASE_MAX, EXP_MAX);
    drain();

    // largest modulus
    write_modulus(MOD_MAX);
    queue_item(BASE_MAX, EXP_MAX);
    queue_item(base_t'(MOD_MAX) - 1, expo_t'(2));
    queue_item(BASE_MAX, expo_t'(1));
    drain();

    // smallest modulus that still reduces
    write_modulus(resid_t'(2));
    queue_item(base_t'(3), EXP_MAX);
    queue_item(base_t'(4), expo_t'(1));
    drain();

    // random phases, each on its own modulus, sender gaps varied per phase
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       phase_mod = resid_t'($urandom) | (resid_t'(1) << (MOD_IN_WIDTH - 1));
        1:       phase_mod = resid_t'($urandom_range(1000, 2));
        2:       phase_mod = MOD_MAX;
        4:       phase_mod = MODULUS_RESET;
        5:       phase_mod = resid_t'($urandom_range(65535, 2));
        default: phase_mod = resid_t'($urandom);
      endcase
      if (p < 3) idle_pct = 9;
      else if (p < 5) idle_pct = 50;
      else idle_pct = 0;
      write_modulus(phase_mod);
      for (int n = 0; n < PHASE_ITEMS; n++) queue_item_struct(random_item(phase_mod));
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && expected_powers.size() == 0) begin
      $display("tb_modular_exponentiation OK");
    end else begin
      $display("tb_modular_exponentiation NOT OK");
    end
    $finish;
  end

endmodule
